[sv/tcw_pkg.sv]
package tcw_pkg;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned CELL_W   = 16;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h07;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT_DEF  = 2'd0,
    MODE_PUT_ATTR = 2'd1,
    MODE_CLEAR    = 2'd2,
    MODE_READ     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_FILL,
    S_RDWAIT,
    S_RESP
  } state_e;

  // Attribute in the high byte, character in the low byte
  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [ATTR_W-1:0] at);
    return {at, ch};
  endfunction

endpackage

[sv/text_console_writer.sv]
// Steps: a character, newline, backspace or out-of-range read goes from request to
// result via accept, execute, result register; an in-range read adds a read wait.
// Clear blanks every cell; a scroll copies rows up and blanks the bottom row for the
// character that causes it. All cell traffic goes through one write and one read port.
// Throughput: one request at a time; the input stalls until the result is registered.
// Reset: async, active low; then every cell is written blank (0x0720), input stalls.
module text_console_writer #(
  parameter int unsigned TEXT_COLUMNS = 80,
  parameter int unsigned TEXT_ROWS    = 25
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tcw_pkg::MODE_W-1:0]   mode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::ATTR_W-1:0]   attr_i,
  input  logic [tcw_pkg::INDEX_W-1:0]  read_index_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tcw_pkg::INDEX_W-1:0]  cursor_position_o,
  output logic [tcw_pkg::CELL_W-1:0]   cell_value_o,
  output logic                         scrolled_o,
  // configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]   cfg_data_i
);

  localparam int unsigned CELL_COUNT = TEXT_ROWS * TEXT_COLUMNS;
  localparam int unsigned COPY_N     = (TEXT_ROWS - 1) * TEXT_COLUMNS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned SWP_W      = $clog2(CELL_COUNT + 1);
  localparam int unsigned WIDE_W     = (SWP_W > tcw_pkg::INDEX_W) ? SWP_W : tcw_pkg::INDEX_W;
  localparam int unsigned ROW_W      = $clog2(TEXT_ROWS);
  localparam int unsigned COL_W      = $clog2(TEXT_COLUMNS);

  tcw_pkg::state_e state_q, state_d;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] cur_idx_q, cur_idx_d;
  logic [SWP_W-1:0]  sweep_q, sweep_d;
  logic              scr_q, scr_d;
  logic [tcw_pkg::CELL_W-1:0] cell_q, cell_d;
  logic [tcw_pkg::ATTR_W-1:0] default_attr_q;

  // latched request
  tcw_pkg::mode_e             mode_q;
  logic [tcw_pkg::CHAR_W-1:0] char_q;
  logic [tcw_pkg::ATTR_W-1:0] attr_q;
  logic [ADDR_W-1:0]          rd_addr_q;
  logic                       rd_ok_q;

  // result register
  logic                         out_valid_q;
  logic [tcw_pkg::INDEX_W-1:0]  pos_q;
  logic [tcw_pkg::CELL_W-1:0]   out_cell_q;
  logic                         out_scr_q;

  // cell store port
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              is_put, is_nl, is_bs, wrap, adv_row, at_last, need_scroll;
  logic              sweep_last, copy_done;
  logic [SWP_W-1:0]  cur_ext, nl_idx, src_idx, dst_idx;
  logic [WIDE_W-1:0] rd_wide, pos_wide;
  logic [tcw_pkg::CELL_W-1:0] blank;

  tcw_cell_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (tcw_pkg::CELL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and decode
  assign in_stall_o  = (state_q != tcw_pkg::S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = (state_q == tcw_pkg::S_RESP) && out_free;

  assign is_put  = (mode_q == tcw_pkg::MODE_PUT_DEF) || (mode_q == tcw_pkg::MODE_PUT_ATTR);
  assign is_nl   = (char_q == tcw_pkg::CODE_NEWLINE);
  assign is_bs   = (char_q == tcw_pkg::CODE_BACKSPACE);
  assign wrap    = !is_nl && !is_bs && (col_q == COL_W'(TEXT_COLUMNS - 1));
  assign adv_row = is_nl || wrap;
  assign at_last = (row_q == ROW_W'(TEXT_ROWS - 1));
  assign need_scroll = is_put && adv_row && at_last;

  assign sweep_last = (sweep_q == SWP_W'(CELL_COUNT - 1));
  assign copy_done  = (sweep_q == SWP_W'(COPY_N));

  assign cur_ext = SWP_W'(cur_idx_q);
  assign nl_idx  = cur_ext - SWP_W'(col_q) + SWP_W'(TEXT_COLUMNS);
  assign src_idx = sweep_q + SWP_W'(TEXT_COLUMNS);
  assign dst_idx = sweep_q - SWP_W'(1);

  assign rd_wide  = WIDE_W'(read_index_i);
  assign pos_wide = WIDE_W'(cur_idx_q);

  assign blank = (state_q == tcw_pkg::S_INIT) ?
                 tcw_pkg::make_cell(tcw_pkg::CODE_SPACE, tcw_pkg::RESET_ATTR) :
                 tcw_pkg::make_cell(tcw_pkg::CODE_SPACE, default_attr_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::S_INIT: begin
        if (sweep_last) state_d = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (accept) state_d = tcw_pkg::S_EXEC;
      end
      tcw_pkg::S_EXEC: begin
        unique case (mode_q)
          tcw_pkg::MODE_PUT_DEF, tcw_pkg::MODE_PUT_ATTR: begin
            state_d = need_scroll ? tcw_pkg::S_SCROLL : tcw_pkg::S_RESP;
          end
          tcw_pkg::MODE_CLEAR: state_d = tcw_pkg::S_FILL;
          tcw_pkg::MODE_READ:  state_d = rd_ok_q ? tcw_pkg::S_RDWAIT : tcw_pkg::S_RESP;
          default:             state_d = tcw_pkg::S_RESP;
        endcase
      end
      tcw_pkg::S_SCROLL: begin
        if (copy_done) state_d = tcw_pkg::S_FILL;
      end
      tcw_pkg::S_FILL: begin
        if (sweep_last) state_d = tcw_pkg::S_RESP;
      end
      tcw_pkg::S_RDWAIT: state_d = tcw_pkg::S_RESP;
      tcw_pkg::S_RESP: begin
        if (out_free) state_d = tcw_pkg::S_IDLE;
      end
      default: state_d = tcw_pkg::S_IDLE;
    endcase
  end

  // Datapath and store port control
  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    cur_idx_d = cur_idx_q;
    sweep_d   = sweep_q;
    scr_d     = scr_q;
    cell_d    = cell_q;
    ram_we    = 1'b0;
    ram_waddr = cur_idx_q;
    ram_wdata = blank;
    ram_raddr = rd_addr_q;
    unique case (state_q)
      tcw_pkg::S_INIT, tcw_pkg::S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q[ADDR_W-1:0];
        sweep_d   = sweep_last ? '0 : sweep_q + SWP_W'(1);
      end
      tcw_pkg::S_IDLE: begin
        if (accept) begin
          scr_d  = 1'b0;
          cell_d = '0;
        end
      end
      tcw_pkg::S_EXEC: begin
        if (mode_q == tcw_pkg::MODE_CLEAR) begin
          row_d     = '0;
          col_d     = '0;
          cur_idx_d = '0;
          sweep_d   = '0;
        end else if (is_put) begin
          if (is_bs) begin
            // step back and blank, nothing at column 0
            if (col_q != '0) begin
              col_d     = col_q - COL_W'(1);
              cur_idx_d = cur_idx_q - ADDR_W'(1);
              ram_we    = 1'b1;
              ram_waddr = cur_idx_q - ADDR_W'(1);
            end
          end else if (!is_nl) begin
            ram_we    = 1'b1;
            ram_wdata = tcw_pkg::make_cell(char_q, attr_q);
            col_d     = col_q + COL_W'(1);
            cur_idx_d = cur_idx_q + ADDR_W'(1);
          end
          // move to the next row, scroll past the bottom
          if (adv_row) begin
            col_d = '0;
            if (at_last) begin
              cur_idx_d = ADDR_W'(COPY_N);
              scr_d     = 1'b1;
              sweep_d   = '0;
            end else begin
              row_d     = row_q + ROW_W'(1);
              cur_idx_d = nl_idx[ADDR_W-1:0];
            end
          end
        end
      end
      tcw_pkg::S_SCROLL: begin
        // read one row below, write back the cell fetched last cycle
        ram_raddr = src_idx[ADDR_W-1:0];
        ram_waddr = dst_idx[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_we    = (sweep_q != '0);
        if (!copy_done) sweep_d = sweep_q + SWP_W'(1);
      end
      tcw_pkg::S_RDWAIT: begin
        cell_d = ram_rdata;
      end
      tcw_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tcw_pkg::S_INIT;
      row_q          <= '0;
      col_q          <= '0;
      cur_idx_q      <= '0;
      sweep_q        <= '0;
      scr_q          <= 1'b0;
      out_valid_q    <= 1'b0;
      default_attr_q <= tcw_pkg::RESET_ATTR;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      cur_idx_q <= cur_idx_d;
      sweep_q   <= sweep_d;
      scr_q     <= scr_d;
      if (cfg_valid_i && cfg_ready_o) default_attr_q <= cfg_data_i;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    if (accept) begin
      mode_q    <= tcw_pkg::mode_e'(mode_i);
      char_q    <= char_code_i;
      attr_q    <= (tcw_pkg::mode_e'(mode_i) == tcw_pkg::MODE_PUT_ATTR) ? attr_i : default_attr_q;
      rd_addr_q <= rd_wide[ADDR_W-1:0];
      rd_ok_q   <= (rd_wide < WIDE_W'(CELL_COUNT));
    end
    if (load_out) begin
      pos_q      <= pos_wide[tcw_pkg::INDEX_W-1:0];
      out_cell_q <= cell_q;
      out_scr_q  <= scr_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = pos_q;
  assign cell_value_o      = out_cell_q;
  assign scrolled_o        = out_scr_q;

  // Checks
  a_cursor_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_idx_q == ADDR_W'(32'(row_q) * TEXT_COLUMNS + 32'(col_q)))
    else $error("cursor index out of step with row and column");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcw_pkg::S_IDLE || state_q == tcw_pkg::S_RESP) |-> !ram_we)
    else $error("cell store written outside a request");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && scr_q) |-> (row_q == ROW_W'(TEXT_ROWS - 1) && col_q == '0))
    else $error("scroll result without cursor at start of bottom row");

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == tcw_pkg::S_EXEC && in_stall_o))
    else $error("request accepted without entering execute");

endmodule

[sv/tcw_cell_ram.sv]
module tcw_cell_ram #(
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned ADDR_W = 11,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write one cell per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
